/* hw/rtl/wsu_pkg.sv */
// ----------------------------------------------------------------------------
// wsu_pkg
// Types and constants shared by the WebSocket frame unmasker modules.
// ----------------------------------------------------------------------------
package wsu_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 64;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned HdrCntW = 3;
  localparam int unsigned KeyIdxW = 2;

  // Second header byte fields
  localparam int unsigned MaskBit = 7;
  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;

  // Count value of the final byte of each multi-byte header field
  localparam logic [HdrCntW-1:0] Ext16LastCnt = 3'd1;
  localparam logic [HdrCntW-1:0] Ext64LastCnt = 3'd7;
  localparam logic [HdrCntW-1:0] KeyLastCnt   = 3'd3;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_EXT16,
    PH_EXT64,
    PH_MASK,
    PH_PAYLOAD
  } wsu_phase_e;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_HDR_TRUNC,
    STATUS_PAY_SHORT
  } wsu_status_e;

  typedef struct packed {
    logic [ByteW-1:0] packet_byte;
    logic             packet_end;
  } wsu_item_t;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             byte_present;
    logic             frame_done;
    wsu_status_e      frame_status;
  } wsu_result_t;

endpackage

/* hw/rtl/wsu_in_reg.sv */
// ----------------------------------------------------------------------------
// wsu_in_reg
// Input register: captures one raw packet byte per cycle from the stream while it is empty or its held byte moves on.
// ----------------------------------------------------------------------------
module wsu_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wsu_pkg::wsu_item_t in_item_i,
  output logic               item_valid_o,
  output wsu_pkg::wsu_item_t item_o,
  input  logic               item_take_i
);
  import wsu_pkg::*;

  logic      valid_q, valid_d;
  wsu_item_t item_q;

  // Refill in the same cycle the held item moves on
  assign in_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* hw/rtl/wsu_parser.sv */
// ----------------------------------------------------------------------------
// wsu_parser
// Header parse state machine, length tracking and payload unmasking.
// ----------------------------------------------------------------------------
module wsu_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  wsu_pkg::wsu_item_t   item_i,
  output logic                 item_take_o,
  input  logic                 res_ready_i,
  output logic                 res_valid_o,
  output wsu_pkg::wsu_result_t res_o
);
  import wsu_pkg::*;

  wsu_phase_e          phase_q, phase_d, phase_nxt;
  logic [HdrCntW-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic                masked_q, masked_d;
  logic [LenW-1:0]     remain_q, remain_d, remain_nxt;
  logic [KeyW-1:0]     key_q, key_d;
  logic [KeyIdxW-1:0]  key_idx_q, key_idx_d;
  logic [ByteW-1:0]    b;
  logic [6:0]          lo7;
  logic                last;
  logic                present;
  logic [ByteW-1:0]    data;
  logic [ByteW-1:0]    key_byte;
  wsu_status_e         status;

  assign b    = item_i.packet_byte;
  assign last = item_i.packet_end;
  assign lo7  = b[6:0];

  assign item_take_o = item_valid_i && res_ready_i;

  // Next phase, before the end-of-packet clear
  always_comb begin
    phase_nxt = phase_q;
    case (phase_q)
      PH_FIRST: begin
        phase_nxt = PH_SECOND;
      end
      PH_SECOND: begin
        if (lo7 == LenCode16) begin
          phase_nxt = PH_EXT16;
        end else if (lo7 == LenCode64) begin
          phase_nxt = PH_EXT64;
        end else begin
          phase_nxt = b[MaskBit] ? PH_MASK : PH_PAYLOAD;
        end
      end
      PH_EXT16: begin
        if (hdr_cnt_q == Ext16LastCnt) begin
          phase_nxt = masked_q ? PH_MASK : PH_PAYLOAD;
        end
      end
      PH_EXT64: begin
        if (hdr_cnt_q == Ext64LastCnt) begin
          phase_nxt = masked_q ? PH_MASK : PH_PAYLOAD;
        end
      end
      PH_MASK: begin
        if (hdr_cnt_q == KeyLastCnt) begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        phase_nxt = PH_PAYLOAD;
      end
      default: begin
        phase_nxt = PH_FIRST;
      end
    endcase
    phase_d = last ? PH_FIRST : phase_nxt;
  end

  // Key byte 0 sits in the top bits
  assign key_byte = key_q[{~key_idx_q, 3'b000} +: ByteW];

  // Datapath and result
  always_comb begin
    hdr_cnt_d  = hdr_cnt_q;
    masked_d   = masked_q;
    remain_nxt = remain_q;
    key_d      = key_q;
    key_idx_d  = key_idx_q;
    present    = 1'b0;
    data       = '0;
    case (phase_q)
      PH_SECOND: begin
        masked_d   = b[MaskBit];
        hdr_cnt_d  = '0;
        remain_nxt = ((lo7 == LenCode16) || (lo7 == LenCode64)) ? '0 : LenW'(lo7);
      end
      PH_EXT16, PH_EXT64: begin
        remain_nxt = {remain_q[LenW-ByteW-1:0], b};
        hdr_cnt_d  = (phase_nxt != phase_q) ? '0 : HdrCntW'(hdr_cnt_q + 1'b1);
      end
      PH_MASK: begin
        key_d     = {key_q[KeyW-ByteW-1:0], b};
        hdr_cnt_d = (phase_nxt != phase_q) ? '0 : HdrCntW'(hdr_cnt_q + 1'b1);
      end
      PH_PAYLOAD: begin
        if (remain_q != '0) begin
          present    = 1'b1;
          data       = b ^ key_byte;
          remain_nxt = LenW'(remain_q - 1'b1);
          key_idx_d  = KeyIdxW'(key_idx_q + 1'b1);
        end
      end
      default: begin
        hdr_cnt_d = hdr_cnt_q;
      end
    endcase

    if (phase_nxt != PH_PAYLOAD) begin
      status = STATUS_HDR_TRUNC;
    end else if (remain_nxt != '0) begin
      status = STATUS_PAY_SHORT;
    end else begin
      status = STATUS_OK;
    end

    remain_d = remain_nxt;
    // Packet end: drop all frame state
    if (last) begin
      hdr_cnt_d = '0;
      masked_d  = 1'b0;
      remain_d  = '0;
      key_d     = '0;
      key_idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_FIRST;
      hdr_cnt_q <= '0;
      masked_q  <= 1'b0;
      remain_q  <= '0;
      key_q     <= '0;
      key_idx_q <= '0;
    end else if (item_take_o) begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      masked_q  <= masked_d;
      remain_q  <= remain_d;
      key_q     <= key_d;
      key_idx_q <= key_idx_d;
    end
  end

  assign res_valid_o        = item_take_o && (present || last);
  assign res_o.payload_byte = data;
  assign res_o.byte_present = present;
  assign res_o.frame_done   = last;
  assign res_o.frame_status = last ? status : STATUS_OK;

endmodule

/* hw/rtl/wsu_out_reg.sv */
// ----------------------------------------------------------------------------
// wsu_out_reg
// Result register: holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module wsu_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  input  wsu_pkg::wsu_result_t res_i,
  output logic                 res_ready_o,
  output logic                 out_valid_o,
  output wsu_pkg::wsu_result_t out_o,
  input  logic                 out_ready_i
);
  import wsu_pkg::*;

  logic        valid_q, valid_d;
  wsu_result_t res_q;

  assign res_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

/* hw/rtl/websocket_frame_unmasker_core.sv */
// ----------------------------------------------------------------------------
// websocket_frame_unmasker_core
// Deframes one WebSocket frame per packet and unmasks its payload bytes.
// An accepted input byte is held in the input register, then its result item in the result register.
// Throughput: 1 byte per cycle while the output side does not stall; the parse state updates once per byte.
// Bytes past the stated length and header bytes yield no result item unless they end the packet.
// Reset (rst_ni low, async): parser back to the first header byte, both
// pipeline registers empty.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] packet_byte
  input  logic       s_axis_tlast_i,   // packet_end
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] payload_byte
  output logic [2:0] m_axis_tuser_o,   // [0] byte_present, [2:1] frame_status
  output logic       m_axis_tlast_o    // frame_done
);
  import wsu_pkg::*;

  wsu_item_t   in_item;
  wsu_item_t   item;
  logic        item_valid;
  logic        item_take;
  logic        res_valid;
  logic        res_ready;
  wsu_result_t res;
  wsu_result_t out_res;

  assign in_item.packet_byte = s_axis_tdata_i;
  assign in_item.packet_end  = s_axis_tlast_i;

  wsu_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  wsu_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_ready_i  (res_ready),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  wsu_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_o       (out_res),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = out_res.payload_byte;
  assign m_axis_tuser_o = {out_res.frame_status, out_res.byte_present};
  assign m_axis_tlast_o = out_res.frame_done;

  // A result that does not close the frame must carry a payload byte
  a_mid_frame_has_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tuser_o[0])
    else $error("result item without byte and without frame end");

  // Status is only reported on the closing item
  a_status_only_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tuser_o[2:1] == STATUS_OK)
    else $error("frame status set before frame end");

  // A truncated header never comes with a payload byte
  a_trunc_no_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[2:1] == STATUS_HDR_TRUNC) |-> !m_axis_tuser_o[0])
    else $error("payload byte emitted with truncated header");

  // The parser only consumes a byte that the input register holds
  a_take_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take |-> item_valid)
    else $error("parser took an item from an empty input register");

endmodule

/* tb/websocket_frame_unmasker_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_unmasker_core_tb
// Sends framed WebSocket packets, one byte per item, into the unmasker and
// checks every result item against a frame parser kept inside the bench.
// A short directed set covers the corner cases. Random frames follow:
// mostly well-formed, with some excess, short, cut and noise packets.
// Both sides idle at random, and the output side stalls for a long stretch.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker_core_tb;
  import wsu_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ItemTarget = 1200;
  localparam int unsigned DrainWait  = 10;
  localparam int unsigned MaxPrinted = 50;

  // length encodings in the second header byte
  localparam int Form7  = 0;
  localparam int Form16 = 1;
  localparam int Form64 = 2;

  typedef enum int {
    FK_EXACT,
    FK_EXCESS,
    FK_SHORT,
    FK_TRUNC,
    FK_NOISE
  } frame_kind_e;

  class unmask_scoreboard;
    wsu_phase_e    phase;
    int unsigned   hdr_cnt;
    bit            masked;
    bit [63:0]     frame_len;
    bit [63:0]     pay_cnt;
    bit [31:0]     key;
    wsu_result_t   expected_q[$];
    int unsigned   errors;

    function new();
      errors = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase     = PH_FIRST;
      hdr_cnt   = 0;
      masked    = 1'b0;
      frame_len = '0;
      pay_cnt   = '0;
      key       = '0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void queue_result(wsu_result_t r);
      expected_q.insert(expected_q.size(), r);
    endfunction

    function wsu_phase_e after_length();
      hdr_cnt = 0;
      return masked ? PH_MASK : PH_PAYLOAD;
    endfunction

    // advance the frame parser by one accepted byte
    function void note_byte(logic [7:0] b, logic last);
      bit          present;
      logic [7:0]  data;
      wsu_status_e status;
      wsu_result_t res;
      present = 1'b0;
      data    = '0;
      case (phase)
        PH_FIRST: begin
          phase = PH_SECOND;
        end
        PH_SECOND: begin
          masked    = b[MaskBit];
          frame_len = '0;
          hdr_cnt   = 0;
          if (b[6:0] == LenCode16) begin
            phase = PH_EXT16;
          end else if (b[6:0] == LenCode64) begin
            phase = PH_EXT64;
          end else begin
            frame_len = 64'(b[6:0]);
            phase     = after_length();
          end
        end
        PH_EXT16, PH_EXT64: begin
          frame_len = {frame_len[55:0], b};
          hdr_cnt++;
          if (hdr_cnt >= ((phase == PH_EXT16) ? 2 : 8)) phase = after_length();
        end
        PH_MASK: begin
          key = {key[23:0], b};
          hdr_cnt++;
          if (hdr_cnt >= 4) begin
            hdr_cnt = 0;
            phase   = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (pay_cnt < frame_len) begin
            data    = b ^ 8'(key >> (8 * (3 - pay_cnt[1:0])));
            present = 1'b1;
            pay_cnt++;
          end
        end
        default: begin
          phase = PH_FIRST;
        end
      endcase
      if (last) begin
        if (phase != PH_PAYLOAD)      status = STATUS_HDR_TRUNC;
        else if (pay_cnt < frame_len) status = STATUS_PAY_SHORT;
        else                          status = STATUS_OK;
        res.payload_byte = data;
        res.byte_present = present;
        res.frame_done   = 1'b1;
        res.frame_status = status;
        queue_result(res);
        clear_parse();
      end else if (present) begin
        res.payload_byte = data;
        res.byte_present = 1'b1;
        res.frame_done   = 1'b0;
        res.frame_status = STATUS_OK;
        queue_result(res);
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < MaxPrinted) $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [7:0] data, logic [2:0] user, logic last);
      wsu_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item data=%02h user=%b last=%b",
                                  data, user, last));
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.payload_byte)
        report_mismatch($sformatf("payload_byte got %02h want %02h",
                                  data, want.payload_byte));
      if (user[0] !== want.byte_present)
        report_mismatch($sformatf("byte_present got %b want %b",
                                  user[0], want.byte_present));
      if (last !== want.frame_done)
        report_mismatch($sformatf("frame_done got %b want %b",
                                  last, want.frame_done));
      if (user[2:1] !== want.frame_status)
        report_mismatch($sformatf("frame_status got %0d want %0d",
                                  user[2:1], want.frame_status));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;   // [7:0] packet_byte
  logic       s_axis_tlast_i;   // packet_end
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;   // [7:0] payload_byte
  logic [2:0] m_axis_tuser_o;   // [0] byte_present, [2:1] frame_status
  logic       m_axis_tlast_o;   // frame_done

  unmask_scoreboard sb;
  logic [7:0]       pkt_q[$];
  int unsigned      item_count;
  int unsigned      src_idle_pct;
  int unsigned      sink_idle_pct;
  logic             sink_hold;

  websocket_frame_unmasker_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  // output side: check accepted items, then pick tready for the next edge
  initial begin
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      m_axis_tready_i <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic void add_byte(input logic [7:0] b);
    pkt_q.insert(pkt_q.size(), b);
  endfunction

  task automatic hold_sink(input int unsigned cycles);
    sink_hold <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    sink_hold <= 1'b0;
  endtask

  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_byte(b, last);
  endtask

  task automatic send_packet();
    foreach (pkt_q[i]) send_item(pkt_q[i], i == pkt_q.size() - 1);
  endtask

  // drop valid and wait until every expected item has come back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // build one frame; cut > 0 keeps only the first cut bytes of the packet
  task automatic run_frame(input bit masked, input int form, input bit [63:0] len,
                           input bit [31:0] key, input int unsigned n_pay,
                           input int unsigned cut);
    pkt_q.delete();
    add_byte(8'($urandom_range(255)));
    case (form)
      Form16: begin
        add_byte({masked, LenCode16});
        for (int i = 1; i >= 0; i--) add_byte(len[8*i +: 8]);
      end
      Form64: begin
        add_byte({masked, LenCode64});
        for (int i = 7; i >= 0; i--) add_byte(len[8*i +: 8]);
      end
      default: add_byte({masked, len[6:0]});
    endcase
    if (masked) for (int i = 3; i >= 0; i--) add_byte(key[8*i +: 8]);
    repeat (n_pay) add_byte(8'($urandom_range(255)));
    if (cut > 0 && cut < pkt_q.size()) begin
      while (pkt_q.size() > cut) void'(pkt_q.pop_back());
    end
    item_count += pkt_q.size();
    send_packet();
  endtask

  task automatic run_random_frame();
    frame_kind_e kind;
    int          form;
    bit [63:0]   len;
    bit          masked;
    int unsigned n_pay;
    int unsigned hdr_len;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60)      kind = FK_EXACT;
    else if (r < 73) kind = FK_EXCESS;
    else if (r < 85) kind = FK_SHORT;
    else if (r < 95) kind = FK_TRUNC;
    else             kind = FK_NOISE;
    if (kind == FK_NOISE) begin
      pkt_q.delete();
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(255)));
      item_count += pkt_q.size();
      send_packet();
      return;
    end
    r      = $urandom_range(99);
    masked = $urandom_range(1);
    if (r < 70) begin
      form = Form7;
      if ($urandom_range(19) == 0)     len = 64'd125;
      else if ($urandom_range(3) == 0) len = 64'($urandom_range(125));
      else                             len = 64'($urandom_range(12));
    end else if (r < 85) begin
      form = Form16;
      len  = ($urandom_range(9) == 0) ? 64'($urandom_range(65535))
                                      : 64'($urandom_range(40));
    end else begin
      form = Form64;
      len  = ($urandom_range(9) == 0) ? {32'($urandom), 32'($urandom)}
                                      : 64'($urandom_range(40));
    end
    if (len > 64'd300 && (kind == FK_EXACT || kind == FK_EXCESS)) kind = FK_SHORT;
    if (len == 0 && kind == FK_SHORT) kind = FK_EXACT;
    hdr_len = 2 + ((form == Form16) ? 2 : (form == Form64) ? 8 : 0) + (masked ? 4 : 0);
    case (kind)
      FK_EXCESS: n_pay = int'(len) + $urandom_range(1, 8);
      FK_SHORT:  n_pay = (len > 64'd300) ? $urandom_range(0, 60)
                                         : $urandom_range(0, int'(len) - 1);
      FK_TRUNC:  n_pay = 0;
      default:   n_pay = int'(len);
    endcase
    run_frame(masked, form, len, $urandom, n_pay,
              (kind == FK_TRUNC) ? $urandom_range(1, hdr_len - 1) : 0);
  endtask

  initial begin
    bit hold_done;
    bit pause_done;
    sb              = new();
    item_count      = 0;
    hold_done       = 1'b0;
    pause_done      = 1'b0;
    src_idle_pct   <= 10;
    sink_idle_pct  <= 10;
    sink_hold      <= 1'b0;
    rst_ni         <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tlast_i  <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // packet of a single byte: header cut at once
    pkt_q.delete();
    add_byte(8'hFF);
    send_packet();
    // zero length, header done on the last byte
    run_frame(1'b0, Form7, 64'd0, 32'h0, 0, 0);
    // all-ones key over a short masked payload
    run_frame(1'b1, Form7, 64'd3, 32'hFFFF_FFFF, 3, 0);
    // largest 16-bit length, packet ends far short of it
    run_frame(1'b0, Form16, 64'hFFFF, 32'h0, 2, 0);
    // 64-bit length with the top bit set, cut inside the length
    run_frame(1'b1, Form64, 64'h8000_0000_0000_0001, 32'h0, 0, 5);
    // bytes past the stated length
    run_frame(1'b0, Form7, 64'd1, 32'h0, 3, 0);

    while (item_count < ItemTarget) begin
      if (!hold_done && item_count >= 300) begin
        hold_done = 1'b1;
        fork
          hold_sink(400);
        join_none
      end
      if (!pause_done && item_count >= 800) begin
        pause_done = 1'b1;
        drain_results();
      end
      // stretch with no idling on either side
      if (item_count >= 450 && item_count < 700) begin
        src_idle_pct  <= 0;
        sink_idle_pct <= 0;
      end else begin
        src_idle_pct  <= 10;
        sink_idle_pct <= 10;
      end
      run_random_frame();
    end

    drain_results();
    repeat (DrainWait) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
